[src/ibo_pkg.sv]
// Shared types, operation codes and bit-operator helpers for the bit operator ALU.
// Used by ibo_merge, intercal_bit_operator_alu and ibo_checker; no dependencies.
package ibo_pkg;

    localparam int DATA_W = 32;
    localparam int HALF_W = 16;
    localparam int OP_W   = 3;

    typedef logic [DATA_W-1:0] word_t;
    typedef logic [OP_W-1:0]   op_t;

    localparam op_t OP_UNARY_AND = 3'd0;
    localparam op_t OP_UNARY_OR  = 3'd1;
    localparam op_t OP_UNARY_XOR = 3'd2;
    localparam op_t OP_MINGLE    = 3'd3;
    localparam op_t OP_SELECT    = 3'd4;

    localparam word_t HALF_LIMIT = 32'h0000_ffff;
    localparam word_t TOP16      = 32'h0000_8000;
    localparam word_t TOP32      = 32'h8000_0000;

    // Rotate right by one within 16 bits when the value fits there, else within 32.
    function automatic word_t rot_right_one(input word_t v);
        word_t carry_in;
        begin
            carry_in = (v > HALF_LIMIT) ? TOP32 : TOP16;
            rot_right_one = v[0] ? ((v >> 1) | carry_in) : (v >> 1);
        end
    endfunction

    // Second operand on even bits, first operand on odd bits.
    function automatic word_t mingle(input word_t odd_src, input word_t even_src);
        word_t r;
        begin
            r = '0;
            for (int i = 0; i < HALF_W; i++)
            begin
                r[2*i]   = even_src[i];
                r[2*i+1] = odd_src[i];
            end
            mingle = r;
        end
    endfunction

endpackage

[src/ibo_merge.sv]
// One level of the select compaction tree: pairs of packed groups merge into one.
// Depends on ibo_pkg for the word width.
module ibo_merge #(
    parameter int LVL = 0
) (
    input  ibo_pkg::word_t                                      data_in,
    input  logic [(ibo_pkg::DATA_W >> LVL)-1:0][LVL:0]          cnt_in,
    output ibo_pkg::word_t                                      data_out,
    output logic [(ibo_pkg::DATA_W >> (LVL+1))-1:0][LVL+1:0]    cnt_out
);
    import ibo_pkg::*;

    localparam int G     = 1 << LVL;
    localparam int NG_OUT = DATA_W >> (LVL + 1);

    // Upper group slides down onto the first free bit above the lower group.
    always_comb
    begin
        for (int j = 0; j < NG_OUT; j++)
        begin
            data_out[2*j*G +: 2*G] = {{G{1'b0}}, data_in[2*j*G +: G]}
                | ({{G{1'b0}}, data_in[2*j*G+G +: G]} << cnt_in[2*j]);
            cnt_out[j] = {1'b0, cnt_in[2*j]} + {1'b0, cnt_in[2*j+1]};
        end
    end

endmodule

[src/intercal_bit_operator_alu.sv]
// Top level of the bit operator ALU: three register stages around a select compaction tree.
// Depends on ibo_pkg and ibo_merge.
//
// Usage:
//   Input channel: in_valid / in_stall with op, first_value, second_value.
//   Output channel: out_valid / out_stall with result. An item moves at a
//   rising edge where valid is high and stall is low.
//   Every item yields exactly one result, in order.
//   An accepted item moves through the stage 1 and stage 2 registers into the
//   output register. Throughput: one item per cycle unless the receiver stalls.
//   The select compaction tree sets the depth: two merge levels in each of the
//   first two stages, the last merge and the result choice in the third.
//   Unary ops and mingle finish in the first stage and ride along.
//   Reset empties all three stages; the block accepts an item in the first
//   cycle after reset.
//   When the receiver stalls, the result holds and the stages behind it fill;
//   in_stall rises only when all three stages hold items and the output is
//   stalled. Nothing is dropped or repeated.
module intercal_bit_operator_alu (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  ibo_pkg::op_t    op,
    input  ibo_pkg::word_t  first_value,
    input  ibo_pkg::word_t  second_value,
    output logic            out_valid,
    input  logic            out_stall,
    output ibo_pkg::word_t  result
);
    import ibo_pkg::*;

    logic adv1, adv2, adv3;
    logic v1_reg, v2_reg, v3_reg;

    // Stage 1 payload
    logic          sel1_reg, sel1_next;
    word_t         other1_reg, other1_next;
    word_t         d1_reg;
    logic [7:0][2:0] c1_reg;

    // Stage 2 payload
    logic          sel2_reg;
    word_t         other2_reg;
    word_t         d2_reg;
    logic [1:0][4:0] c2_reg;

    // Stage 3 payload
    word_t         result_reg, result_next;

    word_t            lv0_data;
    word_t            lv1_data, lv2_data, lv3_data, lv4_data;
    logic [15:0][1:0] lv1_cnt;
    logic [7:0][2:0]  lv2_cnt;
    logic [3:0][3:0]  lv3_cnt;
    logic [1:0][4:0]  lv4_cnt;
    word_t            sel_word;

    assign adv3     = !v3_reg || !out_stall;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_stall = !adv1;

    assign out_valid = v3_reg;
    assign result    = result_reg;

    // Stage 1: unary ops and mingle, first two compaction levels
    always_comb
    begin
        sel1_next = (op == OP_SELECT);
        case (op)
            OP_UNARY_AND: other1_next = first_value & rot_right_one(first_value);
            OP_UNARY_OR:  other1_next = first_value | rot_right_one(first_value);
            OP_UNARY_XOR: other1_next = first_value ^ rot_right_one(first_value);
            OP_MINGLE:    other1_next = mingle(first_value, second_value);
            default:      other1_next = '0;
        endcase
    end

    assign lv0_data = first_value & second_value;

    ibo_merge #(.LVL(0)) u_lv0 (
        .data_in  (lv0_data),
        .cnt_in   (second_value),
        .data_out (lv1_data),
        .cnt_out  (lv1_cnt)
    );

    ibo_merge #(.LVL(1)) u_lv1 (
        .data_in  (lv1_data),
        .cnt_in   (lv1_cnt),
        .data_out (lv2_data),
        .cnt_out  (lv2_cnt)
    );

    // Stage 2: next two compaction levels
    ibo_merge #(.LVL(2)) u_lv2 (
        .data_in  (d1_reg),
        .cnt_in   (c1_reg),
        .data_out (lv3_data),
        .cnt_out  (lv3_cnt)
    );

    ibo_merge #(.LVL(3)) u_lv3 (
        .data_in  (lv3_data),
        .cnt_in   (lv3_cnt),
        .data_out (lv4_data),
        .cnt_out  (lv4_cnt)
    );

    // Stage 3: last merge of the two 16-bit halves, then pick the result
    assign sel_word = {{HALF_W{1'b0}}, d2_reg[HALF_W-1:0]}
        | ({{HALF_W{1'b0}}, d2_reg[DATA_W-1:HALF_W]} << c2_reg[0]);

    assign result_next = sel2_reg ? sel_word : other2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= in_valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            sel1_reg   <= sel1_next;
            other1_reg <= other1_next;
            d1_reg     <= lv2_data;
            c1_reg     <= lv2_cnt;
        end
        if (adv2)
        begin
            sel2_reg   <= sel1_reg;
            other2_reg <= other1_reg;
            d2_reg     <= lv4_data;
            c2_reg     <= lv4_cnt;
        end
        if (adv3)
            result_reg <= result_next;
    end

endmodule

[src/ibo_checker.sv]
// Port-level checks on the bit operator ALU, bound to the top level.
// Depends on ibo_pkg for the operation codes.
module ibo_port_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_stall,
    input  ibo_pkg::op_t    op,
    input  logic            out_valid,
    input  logic            out_stall,
    input  ibo_pkg::word_t  result
);
    import ibo_pkg::*;

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result))
        else $error("stalled result changed");

    // Back-pressure only when the output is full and stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output free");

    // Without output stalls an accepted item reaches the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
        else $error("item did not reach output");

    // Unused op codes yield zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (op > OP_SELECT)) ##1 !out_stall ##1 !out_stall
        |=> result == '0)
        else $error("unused op gave nonzero result");

endmodule

bind intercal_bit_operator_alu ibo_port_checker u_ibo_port_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
);
